[src/tccs_pkg.sv]
// Shared types and constants of the text console engine.
// No dependencies; used by tccs_ctrl, tccs_datapath and the top level.
package tccs_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_BACK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Character codes with special handling
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_SPACE   = 8'd32;
   localparam int         TAB_STEP     = 8;

   localparam logic [7:0] TEXT_COLOR_RESET = 8'h03;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  char_code;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [10:0] cursor_position;
      logic [15:0] read_data;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic copy_step;
      logic blank_step;
      logic init_copy;
      logic init_blank_row;
      logic init_clear;
      logic rsp_fire;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic op_clear;
      logic scroll;
      logic copy_end;
      logic blank_end;
   } status_type;

endpackage

[src/text_console_cursor_scroll_top.sv]
// Text console engine, top level: a character-cell screen with a cursor.
// Put, backspace and read pass through an accept state and an execute state
// that does at most one screen memory access; the result strobe shows in the
// cycle after the execute state, together with the next accept. A put that
// moves below the bottom row scrolls: the screen memory has one write port, so
// the line copy walks the screen one cell per cycle and then blanks the bottom
// line. Clear blanks every cell the same way.
// The result is on rsp_data for exactly one cycle with rsp_strobe high; the
// receiver cannot stall it. Screen contents are undefined after reset until
// the first clear; the cursor is homed and text_color is 3 after reset.
// Depends on tccs_pkg, tccs_ctrl and tccs_datapath.
module text_console_cursor_scroll_top #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  logic              clock,
   input  logic              reset,
   // command channel: item taken when start is high and busy is low
   input  logic              start,
   output logic              busy,
   input  tccs_pkg::req_type req_data,
   // result channel: one-cycle strobe, no back pressure
   output logic              rsp_strobe,
   output tccs_pkg::rsp_type rsp_data,
   // text_color register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   tccs_pkg::cmd_type    cmd;
   tccs_pkg::status_type status;

   // the color register takes a write in any cycle
   assign csr_ready = 1'b1;

   // sequence each item: execute, then optionally copy lines and blank cells
   tccs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // hold cursor, screen memory and result register
   tccs_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_in     (req_data),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_out    (rsp_data)
   );

endmodule

[src/tccs_ctrl.sv]
// Sequencer of the text console engine: one-hot state machine.
// Depends on tccs_pkg for the command and status structs.
module tccs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tccs_pkg::status_type status,
   output tccs_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_COPY  = 4'b0100,
      S_BLANK = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op_clear) begin
               cmd.init_clear = 1'b1;
               state_in       = S_BLANK;
            end else if (status.scroll) begin
               cmd.init_copy = 1'b1;
               state_in      = S_COPY;
            end else begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_end) begin
               cmd.init_blank_row = 1'b1;
               state_in           = S_BLANK;
            end
         end
         S_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.blank_end) begin
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[src/tccs_datapath.sv]
// Datapath of the text console engine: cursor, screen memory, sweep counter,
// color register and result register. Depends on tccs_pkg.
module tccs_datapath #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tccs_pkg::req_type    req_in,
   input  tccs_pkg::cmd_type    cmd,
   output tccs_pkg::status_type status,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_data,
   output logic                 rsp_strobe,
   output tccs_pkg::rsp_type    rsp_out
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int CELL_BITS  = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
   localparam int COL_W      = $clog2(SCREEN_WIDTH);
   localparam int COLX_W     = $clog2(SCREEN_WIDTH + tccs_pkg::TAB_STEP);
   localparam int ADDR_W     = ((CELL_BITS > 11) ? CELL_BITS : 11) + 1;
   localparam int ROW_OW     = (ROW_W > 5) ? ROW_W : 5;
   localparam int COL_OW     = (COL_W > 7) ? COL_W : 7;
   localparam int POS_OW     = (CELL_BITS > 11) ? CELL_BITS : 11;

   tccs_pkg::req_type req_ff;
   logic [7:0]           color_ff;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [CNT_W-1:0]     sweep_ff, sweep_in;
   logic                 copy_pend_ff, copy_pend_in;
   logic [CELL_BITS-1:0] copy_addr_ff, copy_addr_in;
   logic [15:0]          rd_data_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_show_ff, rsp_show_in;
   logic [15:0]          screen_ff [CELL_COUNT];

   logic [CELL_BITS-1:0] cur_pos, bs_addr;
   logic [ADDR_W-1:0]    addr_wide;
   logic                 addr_ok;
   logic [COLX_W-1:0]    tab_sum, inc_sum;
   logic                 wrap;
   logic [15:0]          blank;
   logic                 mem_we, mem_re;
   logic [CELL_BITS-1:0] mem_waddr, mem_raddr;
   logic [15:0]          mem_wdata;
   logic [ROW_OW-1:0]    row_wide;
   logic [COL_OW-1:0]    col_wide;
   logic [POS_OW-1:0]    pos_wide;

   assign cur_pos   = CELL_BITS'(row_ff * SCREEN_WIDTH) + CELL_BITS'(col_ff);
   // one cell back; at home stay on cell zero
   assign bs_addr   = (cur_pos == '0) ? '0 : cur_pos - CELL_BITS'(1);
   assign addr_wide = ADDR_W'(req_ff.cell_address);
   assign addr_ok   = (addr_wide < ADDR_W'(CELL_COUNT));
   assign tab_sum   = COLX_W'(col_ff) + COLX_W'(tccs_pkg::TAB_STEP);
   assign inc_sum   = COLX_W'(col_ff) + COLX_W'(1);
   assign blank     = {color_ff, tccs_pkg::CODE_SPACE};

   // cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      wrap   = 1'b0;
      if (cmd.exec) begin
         case (req_ff.operation)
            tccs_pkg::OP_PUT: begin
               if (req_ff.char_code == tccs_pkg::CODE_NEWLINE) begin
                  col_in = '0;
                  wrap   = 1'b1;
               end else if (req_ff.char_code == tccs_pkg::CODE_TAB) begin
                  if (tab_sum >= COLX_W'(SCREEN_WIDTH)) begin
                     col_in = COL_W'(tab_sum - COLX_W'(SCREEN_WIDTH));
                     wrap   = 1'b1;
                  end else begin
                     col_in = COL_W'(tab_sum);
                  end
               end else begin
                  if (inc_sum >= COLX_W'(SCREEN_WIDTH)) begin
                     col_in = '0;
                     wrap   = 1'b1;
                  end else begin
                     col_in = COL_W'(inc_sum);
                  end
               end
               // stay on the bottom row; the scroll moves the text instead
               if (wrap && (row_ff != ROW_W'(SCREEN_HEIGHT - 1))) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            tccs_pkg::OP_BACK: begin
               if (col_ff != '0) begin
                  col_in = col_ff - COL_W'(1);
               end else if (row_ff != '0) begin
                  row_in = row_ff - ROW_W'(1);
                  col_in = COL_W'(SCREEN_WIDTH - 1);
               end
            end
            tccs_pkg::OP_CLEAR: begin
               row_in = '0;
               col_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.op_clear  = (req_ff.operation == tccs_pkg::OP_CLEAR);
   assign status.scroll    = wrap && (row_ff == ROW_W'(SCREEN_HEIGHT - 1));
   assign status.copy_end  = (sweep_ff == CNT_W'(CELL_COUNT));
   assign status.blank_end = (sweep_ff == CNT_W'(CELL_COUNT - 1));

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_pos;
      mem_wdata = blank;
      mem_re    = 1'b0;
      mem_raddr = sweep_ff[CELL_BITS-1:0];
      if (cmd.exec) begin
         case (req_ff.operation)
            tccs_pkg::OP_PUT: begin
               if ((req_ff.char_code != tccs_pkg::CODE_NEWLINE) &&
                   (req_ff.char_code != tccs_pkg::CODE_TAB)) begin
                  mem_we    = 1'b1;
                  mem_wdata = {color_ff, req_ff.char_code};
               end
            end
            tccs_pkg::OP_BACK: begin
               mem_we    = 1'b1;
               mem_waddr = bs_addr;
            end
            tccs_pkg::OP_READ: begin
               mem_re    = 1'b1;
               mem_raddr = addr_wide[CELL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      if (cmd.copy_step) begin
         // read one line below, write the cell read last cycle
         mem_re    = !status.copy_end;
         mem_we    = copy_pend_ff;
         mem_waddr = copy_addr_ff;
         mem_wdata = rd_data_ff;
      end
      if (cmd.blank_step) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff[CELL_BITS-1:0];
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.init_copy) begin
         sweep_in = CNT_W'(SCREEN_WIDTH);
      end else if (cmd.init_blank_row) begin
         sweep_in = CNT_W'(CELL_COUNT - SCREEN_WIDTH);
      end else if (cmd.init_clear) begin
         sweep_in = '0;
      end else if (cmd.copy_step || cmd.blank_step) begin
         sweep_in = sweep_ff + CNT_W'(1);
      end
   end

   assign copy_pend_in = cmd.copy_step && !status.copy_end;
   assign copy_addr_in = sweep_ff[CELL_BITS-1:0] - CELL_BITS'(SCREEN_WIDTH);
   assign rsp_show_in  = (req_ff.operation == tccs_pkg::OP_READ) && addr_ok;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_in;
      end
      sweep_ff     <= sweep_in;
      copy_addr_ff <= copy_addr_in;
      if (cmd.rsp_fire) begin
         rsp_show_ff <= rsp_show_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         color_ff     <= tccs_pkg::TEXT_COLOR_RESET;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= cmd.rsp_fire;
         if (csr_valid) begin
            color_ff <= csr_data;
         end
      end
   end

   assign row_wide = ROW_OW'(row_ff);
   assign col_wide = COL_OW'(col_ff);
   assign pos_wide = POS_OW'(cur_pos);

   assign rsp_strobe              = rsp_valid_ff;
   assign rsp_out.cursor_row      = row_wide[4:0];
   assign rsp_out.cursor_column   = col_wide[6:0];
   assign rsp_out.cursor_position = pos_wide[10:0];
   assign rsp_out.read_data       = rsp_show_ff ? rd_data_ff : 16'h0000;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the text console engine.
// Depends on tccs_pkg and text_console_cursor_scroll_top; reads no files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tccs_pkg::*;

   localparam int          WIDTH        = 80;
   localparam int          HEIGHT       = 25;
   localparam int          CELLS        = WIDTH * HEIGHT;
   localparam int          ADDR_MAX     = 2047;
   localparam int          STREAM_ITEMS = 1400;
   localparam int          PHASES       = 7;
   // Worst case is every item scrolling plus sender gaps; allow several times that.
   localparam longint      CYCLE_LIMIT  = 12_000_000;
   localparam logic [7:0]  CHAR_A       = 8'h41;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic       busy;
   req_type    req_data  = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = 8'h00;

   // Shadow of the screen, the cursor and the color register.
   logic [15:0] screen_shadow [CELLS];
   int unsigned cursor_row_q;
   int unsigned cursor_col_q;
   logic [7:0]  text_attr;

   // Cursor/cell reports still owed by the block, oldest first.
   rsp_type     pending_reports [$];
   int unsigned mismatches;
   longint      cycle_count = 0;
   bit          steady_drive;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_console_cursor_scroll_top #(
      .SCREEN_WIDTH (WIDTH),
      .SCREEN_HEIGHT(HEIGHT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------
   // Screen shadow
   // ------------------------------------------------------------------

   // Store a character with the current attribute; out-of-screen is dropped.
   function automatic void store_cell(int unsigned row, int unsigned col,
                                      logic [7:0] code);
      int unsigned idx;
      idx = row * WIDTH + col;
      if (idx < CELLS) screen_shadow[idx] = {text_attr, code};
   endfunction

   // Advance one row; on the bottom row shift every line up and blank the
   // new bottom line instead.
   function automatic void line_feed();
      if (cursor_row_q >= HEIGHT - 1) begin
         cursor_row_q = HEIGHT - 1;
         for (int i = 0; i < CELLS - WIDTH; i++) screen_shadow[i] = screen_shadow[i + WIDTH];
         for (int i = CELLS - WIDTH; i < CELLS; i++) screen_shadow[i] = {text_attr, CODE_SPACE};
      end else begin
         cursor_row_q++;
      end
   endfunction

   // Apply one item to the shadow and return the report the block must give.
   function automatic rsp_type console_apply(req_type item);
      rsp_type     report;
      logic [15:0] cell_word;
      cell_word = '0;
      case (item.operation)
         OP_PUT: begin
            if (item.char_code == CODE_NEWLINE) begin
               line_feed();
               cursor_col_q = 0;
            end else if (item.char_code == CODE_TAB) begin
               cursor_col_q += TAB_STEP;
               if (cursor_col_q >= WIDTH) begin
                  cursor_col_q -= WIDTH;
                  line_feed();
               end
            end else begin
               store_cell(cursor_row_q, cursor_col_q, item.char_code);
               cursor_col_q++;
               if (cursor_col_q >= WIDTH) begin
                  cursor_col_q = 0;
                  line_feed();
               end
            end
         end
         OP_BACK: begin
            // At column zero step to the end of the row above; at home stay.
            if (cursor_col_q == 0) begin
               if (cursor_row_q != 0) begin
                  cursor_row_q--;
                  cursor_col_q = WIDTH - 1;
               end
            end else begin
               cursor_col_q--;
            end
            store_cell(cursor_row_q, cursor_col_q, CODE_SPACE);
         end
         OP_READ: begin
            if (item.cell_address < CELLS) cell_word = screen_shadow[item.cell_address];
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_shadow[i] = {text_attr, CODE_SPACE};
            cursor_row_q = 0;
            cursor_col_q = 0;
         end
         default: begin
         end
      endcase
      report.cursor_row      = cursor_row_q[4:0];
      report.cursor_column   = cursor_col_q[6:0];
      report.cursor_position = 11'(cursor_row_q * WIDTH + cursor_col_q);
      report.read_data       = cell_word;
      return report;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   function automatic req_type make_item(logic [1:0] op, logic [7:0] code,
                                         logic [10:0] addr);
      req_type item;
      item.operation    = op;
      item.char_code    = code;
      item.cell_address = addr;
      return item;
   endfunction

   // Present one item and hold it until the block takes it. Start stays high
   // after the accept so back-to-back items never drop it; only an idle gap
   // lowers it.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = 0;
      if (!steady_drive && $urandom_range(99) < 20) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      pending_reports.push_back(console_apply(item));
   endtask

   // Drop start and wait until every owed report has come back.
   task automatic settle();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write text_color while the block is idle.
   task automatic write_text_color(input logic [7:0] value);
      settle();
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      text_attr = value;
   endtask

   // ------------------------------------------------------------------
   // Report checker: each strobe is matched against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_reports
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $error("report with nothing pending: row %0d column %0d",
                   rsp_data.cursor_row, rsp_data.cursor_column);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_data.cursor_row !== want.cursor_row) begin
               $error("cursor_row: expected %0d, actual %0d",
                      want.cursor_row, rsp_data.cursor_row);
               mismatches++;
            end
            if (rsp_data.cursor_column !== want.cursor_column) begin
               $error("cursor_column: expected %0d, actual %0d",
                      want.cursor_column, rsp_data.cursor_column);
               mismatches++;
            end
            if (rsp_data.cursor_position !== want.cursor_position) begin
               $error("cursor_position: expected %0d, actual %0d",
                      want.cursor_position, rsp_data.cursor_position);
               mismatches++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h",
                      want.read_data, rsp_data.read_data);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Puts and backspaces before the first clear; nothing is read back since
   // the screen is still undefined. Backspace at column zero of row one
   // lands on the last column of row zero.
   task automatic test_before_clear();
      send_item(make_item(OP_PUT, 8'hFF, 11'(ADDR_MAX)));
      send_item(make_item(OP_PUT, CODE_NEWLINE, 11'd0));
      send_item(make_item(OP_BACK, 8'h00, 11'(ADDR_MAX)));
      send_item(make_item(OP_BACK, 8'hFF, 11'd0));
   endtask

   // Clear with the reset color, then read both ends and beyond the screen.
   task automatic test_clear_screen();
      send_item(make_item(OP_CLEAR, 8'h00, 11'd0));
      send_item(make_item(OP_READ, 8'hFF, 11'd0));
      send_item(make_item(OP_READ, 8'h00, 11'(ADDR_MAX)));
      send_item(make_item(OP_READ, 8'h00, 11'(CELLS - 1)));
   endtask

   // Control-like codes other than tab and newline are printed as is.
   task automatic test_character_codes();
      send_item(make_item(OP_PUT, 8'h00, 11'($urandom_range(ADDR_MAX))));
      send_item(make_item(OP_PUT, 8'hFF, 11'($urandom_range(ADDR_MAX))));
      send_item(make_item(OP_PUT, 8'd13, 11'($urandom_range(ADDR_MAX))));
      send_item(make_item(OP_PUT, 8'd254, 11'($urandom_range(ADDR_MAX))));
      send_item(make_item(OP_READ, 8'h00, 11'd1));
   endtask

   // From column 4, the tenth tab passes the right edge and wraps to
   // column 4 of the next row.
   task automatic test_tab_wrap();
      repeat (10) send_item(make_item(OP_PUT, CODE_TAB, 11'($urandom_range(ADDR_MAX))));
   endtask

   // Backspace at home keeps the cursor and blanks cell 0.
   task automatic test_backspace_at_home();
      send_item(make_item(OP_CLEAR, 8'hFF, 11'(ADDR_MAX)));
      send_item(make_item(OP_BACK, 8'h00, 11'd0));
      send_item(make_item(OP_READ, 8'h00, 11'd0));
   endtask

   // Attribute extremes: all ones for a clear and a put, all zeros for a
   // blanking backspace.
   task automatic test_color_extremes();
      write_text_color(8'hFF);
      send_item(make_item(OP_CLEAR, 8'h00, 11'd0));
      send_item(make_item(OP_PUT, CHAR_A, 11'd0));
      send_item(make_item(OP_READ, 8'h00, 11'd0));
      write_text_color(8'h00);
      send_item(make_item(OP_BACK, 8'h00, 11'd0));
      send_item(make_item(OP_READ, 8'h00, 11'd0));
   endtask

   // Mostly text lines with random content: printable runs, newlines and
   // tabs that push the cursor past the bottom row and scroll, with
   // backspaces, reads near the cursor and rare clears. A few items are
   // fully random noise. Each phase runs under a new color, and one phase
   // drives back to back with no gaps.
   task automatic test_text_stream();
      int unsigned per_phase;
      int unsigned pick;
      int unsigned here;
      int unsigned back;
      logic [1:0]  op;
      logic [7:0]  code;
      logic [10:0] addr;
      per_phase = STREAM_ITEMS / PHASES;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_text_color(8'($urandom_range(255)));
         steady_drive = (phase == 2);
         for (int n = 0; n < per_phase; n++) begin
            code = 8'($urandom_range(255));
            addr = 11'($urandom_range(ADDR_MAX));
            pick = $urandom_range(99);
            if ($urandom_range(99) < 5) begin
               op = 2'($urandom_range(3));
            end else if (pick < 62) begin
               op = OP_PUT;
            end else if (pick < 68) begin
               op   = OP_PUT;
               code = CODE_NEWLINE;
            end else if (pick < 76) begin
               op   = OP_PUT;
               code = CODE_TAB;
            end else if (pick < 86) begin
               op = OP_BACK;
            end else if (pick < 99) begin
               op = OP_READ;
               // Favor cells just written behind the cursor.
               here = cursor_row_q * WIDTH + cursor_col_q;
               back = $urandom_range(0, WIDTH);
               pick = $urandom_range(99);
               if (pick < 10) addr = 11'($urandom_range(CELLS, ADDR_MAX));
               else if (pick < 60 && here >= back) addr = 11'(here - back);
               else addr = 11'($urandom_range(CELLS - 1));
            end else begin
               op = OP_CLEAR;
            end
            send_item(make_item(op, code, addr));
         end
      end
      steady_drive = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      cursor_row_q = 0;
      cursor_col_q = 0;
      text_attr    = TEXT_COLOR_RESET;
      mismatches   = 0;
      steady_drive = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_before_clear();
      test_clear_screen();
      test_character_codes();
      test_tab_wrap();
      test_backspace_at_home();
      test_color_extremes();
      test_text_stream();

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
